>>> design/ardl_pkg.sv
// Shared types and constants for the audio ring delay line.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ardl_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = SAMPLE_W + 1;
    localparam int DELAY_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DELAY_W;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERP = 2'd1;

    // Reciprocal scaling for the delay reduction modulo the depth
    localparam int RECIP_SH = 24;

    // Input hold steps after a delay write (quotient, remainder, index load)
    localparam logic [1:0] CFG_STEPS = 2'd3;
    localparam logic [1:0] CFG_LOAD  = 2'd1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Configuration state seen by the store
    typedef struct packed {
        logic busy;
        logic recalc;
        logic interp;
    } t_cfg_ctl;

    // Read stage handed from the store to the output stage
    typedef struct packed {
        logic    valid;
        logic    interp;
        t_sample a;
        t_sample b;
    } t_rd_pair;

endpackage

`default_nettype wire

>>> design/audio_ring_delay_line.sv
// Top level of the audio ring delay line.
// Depends on ardl_pkg, ardl_cfg, ardl_store and ardl_out.
//
//   Channel  Direction  Handshake                Payload
//   input    in         i_in_valid / o_in_stall  i_sample_in  (16 b signed)
//   output   out        o_out_valid / i_out_stall o_sample_out (16 b signed)
//   config   in         i_cfg_we (no wait)       i_cfg_idx, i_cfg_data
//
// One sample per cycle while no delay reload or output stall holds the input.
// The memory takes one write and two reads per cycle (delayed tap, next tap).
// A delay_length write holds the input while the delay is reduced modulo
// DEPTH and the read indexes reload.
// Reset needs no clearing pass: a write pointer and wrap flag mark unwritten
// entries, which read as zero. A stalled output holds two requests in flight.
`timescale 1ns / 1ps
`default_nettype none

module audio_ring_delay_line #(
    parameter int DEPTH = 4096
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire ardl_pkg::t_sample               i_sample_in,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output ardl_pkg::t_sample                    o_sample_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [ardl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ardl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ardl_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_cfg_ctl      w_ctl;
    logic [AW-1:0] w_dmod;
    t_rd_pair      w_rd;
    logic          w_take;

    // Configuration and delay reduction
    ardl_cfg #(
        .DEPTH (DEPTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_ctl      (w_ctl),
        .o_dmod     (w_dmod)
    );

    // Sample memory and read stage
    ardl_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample_in (i_sample_in),
        .i_ctl       (w_ctl),
        .i_dmod      (w_dmod),
        .i_take      (w_take),
        .o_rd        (w_rd)
    );

    // Averaging and result register
    ardl_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd         (w_rd),
        .o_take       (w_take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out)
    );

    // No request may enter while the delay is being reduced
    a_busy_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.busy |-> o_in_stall)
        else $error("request accepted during delay reload");

    // A delay write starts the reload interlock
    a_delay_write_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx == REG_DELAY)) |=> o_in_stall)
        else $error("delay write did not hold the input");

    // Every accepted request reaches the read stage
    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> w_rd.valid)
        else $error("accepted request lost before the read stage");

    // A read stage item waits only while the result register is blocked
    a_stage_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rd.valid && w_take && !(i_in_valid && !o_in_stall)) |=> !w_rd.valid)
        else $error("read stage repeated a result");

endmodule

`default_nettype wire

>>> design/ardl_cfg.sv
// Configuration registers and delay reduction modulo the store depth.
// Depends on ardl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ardl_cfg #(
    parameter int DEPTH = 4096
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ardl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ardl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ardl_pkg::t_cfg_ctl                  o_ctl,
    output logic [$clog2(DEPTH)-1:0]            o_dmod
);
    import ardl_pkg::*;

    localparam int AW     = $clog2(DEPTH);
    localparam int DW     = AW + 1;
    localparam int PROD_W = DELAY_W + RECIP_SH;
    localparam int QD_W   = DELAY_W + DW;
    localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'((64'd1 << RECIP_SH) / DEPTH);
    localparam logic [QD_W-1:0]     DEPTH_Q = QD_W'(DEPTH);

    logic [DELAY_W-1:0] r_delay_raw;
    logic [DELAY_W-1:0] r_quot;
    logic [AW-1:0]      r_dmod;
    logic               r_interp;
    logic [1:0]         r_cnt;
    logic [1:0]         n_cnt;

    logic [PROD_W-1:0]  w_prod;
    logic [QD_W-1:0]    w_qd;
    logic [QD_W-1:0]    w_rem;
    logic [QD_W-1:0]    w_rem_fix;

    // Estimate quotient by reciprocal; it is exact or one short
    assign w_prod = PROD_W'(r_delay_raw) * PROD_W'(RECIP);

    // Remainder with one correction step
    assign w_qd      = QD_W'(r_quot) * DEPTH_Q;
    assign w_rem     = QD_W'(r_delay_raw) - w_qd;
    assign w_rem_fix = (w_rem >= DEPTH_Q) ? (w_rem - DEPTH_Q) : w_rem;

    // Count down the reduction steps after a delay write
    always_comb begin
        n_cnt = r_cnt;
        if (i_cfg_we && (i_cfg_idx == REG_DELAY)) begin
            n_cnt = CFG_STEPS;
        end else if (r_cnt != 2'd0) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 2'd0;
            r_dmod   <= '0;
            r_interp <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cfg_we && (i_cfg_idx == REG_INTERP)) begin
                r_interp <= i_cfg_data[0];
            end
            if (r_cnt == CFG_LOAD + 2'd1) begin
                r_dmod <= AW'(w_rem_fix);
            end
        end
    end

    // Payload of the reduction pipeline
    always_ff @(posedge i_clk) begin
        if (i_cfg_we && (i_cfg_idx == REG_DELAY)) begin
            r_delay_raw <= i_cfg_data[DELAY_W-1:0];
        end
        if (r_cnt == CFG_STEPS) begin
            r_quot <= w_prod[PROD_W-1:RECIP_SH];
        end
    end

    assign o_ctl.busy   = (r_cnt != 2'd0);
    assign o_ctl.recalc = (r_cnt == CFG_LOAD);
    assign o_ctl.interp = r_interp;
    assign o_dmod       = r_dmod;

endmodule

`default_nettype wire

>>> design/ardl_store.sv
// Sample memory with write and read indexes, fill tracking and forwarding.
// Depends on ardl_pkg; takes its control from ardl_cfg.
`timescale 1ns / 1ps
`default_nettype none

module ardl_store #(
    parameter int DEPTH = 4096
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire ardl_pkg::t_sample          i_sample_in,
    input  wire ardl_pkg::t_cfg_ctl         i_ctl,
    input  wire logic [$clog2(DEPTH)-1:0]   i_dmod,
    input  wire logic                       i_take,
    output ardl_pkg::t_rd_pair              o_rd
);
    import ardl_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int AW1 = AW + 1;
    localparam logic [AW-1:0]  LAST    = AW'(DEPTH - 1);
    localparam logic [AW1-1:0] DEPTH_X = AW1'(DEPTH);

    t_sample r_mem [DEPTH];

    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_wr_nx;
    logic [AW-1:0] r_rd;
    logic [AW-1:0] r_rd_nx;
    logic          r_wrapped;
    logic          r_s1_valid;
    logic          n_s1_valid;

    t_sample       r_q_a;
    t_sample       r_q_b;
    t_sample       r_smp;
    logic          r_fwd_a;
    logic          r_fwd_b;
    logic          r_ok_a;
    logic          r_ok_b;
    logic          r_interp;

    logic          w_accept;
    logic [AW1-1:0] w_d0;
    logic [AW1-1:0] w_d1;
    logic [AW-1:0]  w_rd_new;
    logic [AW-1:0]  w_rd_nx_new;

    // Hold input while the delay settles or the read stage cannot move
    assign o_in_stall = i_ctl.busy | (r_s1_valid & ~i_take);
    assign w_accept   = i_in_valid & ~o_in_stall;

    // Read indexes from the write indexes minus the reduced delay
    assign w_d0 = {1'b0, r_wr} - {1'b0, i_dmod};
    assign w_d1 = {1'b0, r_wr_nx} - {1'b0, i_dmod};
    assign w_rd_new    = w_d0[AW] ? AW'(w_d0 + DEPTH_X) : w_d0[AW-1:0];
    assign w_rd_nx_new = w_d1[AW] ? AW'(w_d1 + DEPTH_X) : w_d1[AW-1:0];

    // Advance indexes per request, reload them after a delay write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr      <= '0;
            r_wr_nx   <= AW'(1);
            r_rd      <= '0;
            r_rd_nx   <= AW'(1);
            r_wrapped <= 1'b0;
        end else if (w_accept) begin
            r_wr    <= r_wr_nx;
            r_wr_nx <= (r_wr_nx == LAST) ? '0 : r_wr_nx + AW'(1);
            r_rd    <= r_rd_nx;
            r_rd_nx <= (r_rd_nx == LAST) ? '0 : r_rd_nx + AW'(1);
            if (r_wr == LAST) begin
                r_wrapped <= 1'b1;
            end
        end else if (i_ctl.recalc) begin
            r_rd    <= w_rd_new;
            r_rd_nx <= w_rd_nx_new;
        end
    end

    // Write the new sample and read both taps, old data on a collision
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem[r_wr] <= i_sample_in;
            r_q_a       <= r_mem[r_rd];
            r_q_b       <= r_mem[r_rd_nx];
        end
    end

    // Capture forwarding and fill flags with the read
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_smp    <= i_sample_in;
            r_fwd_a  <= (r_rd == r_wr);
            r_fwd_b  <= (r_rd_nx == r_wr);
            r_ok_a   <= r_wrapped | (r_rd < r_wr);
            r_ok_b   <= r_wrapped | (r_rd_nx < r_wr);
            r_interp <= i_ctl.interp;
        end
    end

    // Read stage occupancy
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_accept) begin
            n_s1_valid = 1'b1;
        end else if (i_take) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    // Forward the fresh sample, read unwritten entries as zero
    assign o_rd.valid  = r_s1_valid;
    assign o_rd.interp = r_interp;
    assign o_rd.a      = r_fwd_a ? r_smp : (r_ok_a ? r_q_a : '0);
    assign o_rd.b      = r_fwd_b ? r_smp : (r_ok_b ? r_q_b : '0);

endmodule

`default_nettype wire

>>> design/ardl_out.sv
// Output stage: optional average of the two taps and the result register.
// Depends on ardl_pkg; fed by ardl_store.
`timescale 1ns / 1ps
`default_nettype none

module ardl_out (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ardl_pkg::t_rd_pair i_rd,
    output logic                    o_take,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ardl_pkg::t_sample       o_sample_out
);
    import ardl_pkg::*;

    logic             r_valid;
    t_sample          r_data;
    logic [SUM_W-1:0] w_sum;
    logic [SUM_W:0]   w_adj;
    t_sample          w_result;

    // Average with the halving truncated toward zero
    assign w_sum    = SUM_W'(i_rd.a) + SUM_W'(i_rd.b);
    assign w_adj    = {w_sum[SUM_W-1], w_sum} + {{SUM_W{1'b0}}, w_sum[SUM_W-1]};
    assign w_result = i_rd.interp ? w_adj[SAMPLE_W:1] : i_rd.a;

    // Take a new result when the register is empty or being drained
    assign o_take = ~r_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_rd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_rd.valid) begin
            r_data <= w_result;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_sample_out = r_data;

endmodule

`default_nettype wire
